/* hdl/vcd_pkg.sv */
package vcd_pkg;

  localparam int MaxDigits = 64;
  localparam int CntW      = $clog2(MaxDigits + 1);
  localparam int AddrW     = $clog2(MaxDigits);

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NINE = 8'd57;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NONDIGIT = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       clr;
    logic       mode;
    logic       en;
    logic [3:0] digit;
  } alu_ctl_t;

  function automatic logic [3:0] clamp9(input logic [3:0] v);
    clamp9 = (v < 4'd10) ? v : 4'd9;
  endfunction

  function automatic logic [3:0] tab_inv(input logic [3:0] v);
    case (v)
      4'd1:    tab_inv = 4'd4;
      4'd2:    tab_inv = 4'd3;
      4'd3:    tab_inv = 4'd2;
      4'd4:    tab_inv = 4'd1;
      4'd0:    tab_inv = 4'd0;
      default: tab_inv = clamp9(v);
    endcase
  endfunction

  // permutation P: row 1 generates the rest by repeated application
  function automatic logic [3:0] perm1(input logic [3:0] v);
    case (clamp9(v))
      4'd0:    perm1 = 4'd1;
      4'd1:    perm1 = 4'd5;
      4'd2:    perm1 = 4'd7;
      4'd3:    perm1 = 4'd6;
      4'd4:    perm1 = 4'd2;
      4'd5:    perm1 = 4'd8;
      4'd6:    perm1 = 4'd3;
      4'd7:    perm1 = 4'd0;
      4'd8:    perm1 = 4'd9;
      default: perm1 = 4'd4;
    endcase
  endfunction

  function automatic logic [3:0] tab_p(input logic [2:0] pos, input logic [3:0] v);
    logic [3:0] r;
    r = clamp9(v);
    for (int k = 0; k < 7; k++) begin
      if (k < int'(pos)) r = perm1(r);
    end
    tab_p = r;
  endfunction

  // dihedral group D5 product
  function automatic logic [3:0] tab_d(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] s;
    x = clamp9(a);
    y = clamp9(b);
    if (x < 4'd5 && y < 4'd5) begin
      s = x + y;
      tab_d = (s >= 4'd5) ? s - 4'd5 : s;
    end else if (x < 4'd5) begin
      s = (y - 4'd5) + x;
      tab_d = 4'd5 + ((s >= 4'd5) ? s - 4'd5 : s);
    end else if (y < 4'd5) begin
      s = (x - 4'd5) + 4'd5 - y;
      tab_d = 4'd5 + ((s >= 4'd5) ? s - 4'd5 : s);
    end else begin
      s = (x - 4'd5) + 4'd5 - (y - 4'd5);
      tab_d = (s >= 4'd5) ? s - 4'd5 : s;
    end
  endfunction

endpackage

/* hdl/vcd_mem.sv */
module vcd_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [vcd_pkg::AddrW-1:0] waddr_i,
  input  logic [3:0]                wdata_i,
  input  logic                      re_i,
  input  logic [vcd_pkg::AddrW-1:0] raddr_i,
  output logic [3:0]                rdata_o
);

  logic [3:0] mem [vcd_pkg::MaxDigits];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* hdl/vcd_alu.sv */
module vcd_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vcd_pkg::alu_ctl_t ctl_i,
  output logic [3:0]        prod_o
);

  logic [3:0] prod_q, prod_d;
  logic [2:0] pos_q, pos_d;

  always_comb begin
    prod_d = prod_q;
    pos_d  = pos_q;
    if (ctl_i.clr) begin
      prod_d = 4'd0;
      pos_d  = {2'b00, ctl_i.mode};
    end else if (ctl_i.en) begin
      prod_d = vcd_pkg::tab_d(prod_q, vcd_pkg::tab_p(pos_q, ctl_i.digit));
      pos_d  = pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= 4'd0;
      pos_q  <= 3'd0;
    end else begin
      prod_q <= prod_d;
      pos_q  <= pos_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* hdl/verhoeff_check_digit.sv */
// Verhoeff check digit unit. Send one ASCII character per request with
// start while busy is low; last marks the final character. Digits are
// stored (up to 64); on the final character the stored digits are folded
// right to left through one shared table unit, one digit per cycle, fed by
// the single read port of the digit memory. After the characters of a
// string come the walk and then the result state; on an error or an
// empty string the walk is skipped. The result appears for exactly one
// cycle with valid_o and cannot be stalled: the receiver must take it then.
// mode_we_i/mode_wdata_i write the mode (0 validate, 1 generate); the user
// must write it only while busy is low, as the block does not enforce this.
module verhoeff_check_digit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mode_we_i,
  input  logic       mode_wdata_i,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] digit_char_i,
  input  logic       last_i,
  output logic       valid_o,
  output logic [5:0] check_char_o,
  output logic       check_ok_o,
  output logic [1:0] status_o
);

  localparam int CntW  = vcd_pkg::CntW;
  localparam int AddrW = vcd_pkg::AddrW;

  vcd_pkg::state_e state_q, state_d;

  logic            mode_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] left_q, left_d;
  logic [1:0]      err_q, err_d;
  logic            fire_q, fire_d;

  logic            accept;
  logic            is_digit;
  logic            room;
  logic            mem_we;
  logic            mem_re;
  logic [3:0]      mem_rdata;
  logic [3:0]      prod;
  logic [5:0]      gen_char;
  vcd_pkg::alu_ctl_t alu_ctl;

  assign accept   = start && !busy;
  assign is_digit = (digit_char_i >= vcd_pkg::ASCII_ZERO) &&
                    (digit_char_i <= vcd_pkg::ASCII_NINE);
  assign room     = cnt_q < CntW'(vcd_pkg::MaxDigits);
  assign mem_we   = accept && is_digit && room;
  assign mem_re   = (state_q == vcd_pkg::ST_WALK) && (left_q != '0);

  vcd_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (4'(digit_char_i - vcd_pkg::ASCII_ZERO)),
    .re_i    (mem_re),
    .raddr_i (AddrW'(left_q - CntW'(1))),
    .rdata_o (mem_rdata)
  );

  assign alu_ctl.clr   = accept && last_i;
  assign alu_ctl.mode  = mode_q;
  assign alu_ctl.en    = fire_q;
  assign alu_ctl.digit = mem_rdata;

  vcd_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .prod_o (prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    left_d  = left_q;
    fire_d  = 1'b0;
    case (state_q)
      vcd_pkg::ST_IDLE: begin
        if (accept) begin
          if (!is_digit) begin
            if (err_q == vcd_pkg::STAT_OK) err_d = vcd_pkg::STAT_NONDIGIT;
          end else if (!room) begin
            if (err_q == vcd_pkg::STAT_OK) err_d = vcd_pkg::STAT_OVERFLOW;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
          if (last_i) begin
            left_d = cnt_d;
            if (err_d != vcd_pkg::STAT_OK || cnt_d == '0) begin
              state_d = vcd_pkg::ST_DONE;
            end else begin
              state_d = vcd_pkg::ST_WALK;
            end
          end
        end
      end
      vcd_pkg::ST_WALK: begin
        if (left_q != '0) begin
          left_d = left_q - CntW'(1);
          fire_d = 1'b1;
        end else if (!fire_q) begin
          state_d = vcd_pkg::ST_DONE;
        end
      end
      vcd_pkg::ST_DONE: begin
        cnt_d   = '0;
        err_d   = vcd_pkg::STAT_OK;
        state_d = vcd_pkg::ST_IDLE;
      end
      default: begin
        state_d = vcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vcd_pkg::ST_IDLE;
      mode_q  <= 1'b0;
      cnt_q   <= '0;
      err_q   <= vcd_pkg::STAT_OK;
      left_q  <= '0;
      fire_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      left_q  <= left_d;
      fire_q  <= fire_d;
      if (mode_we_i) mode_q <= mode_wdata_i;
    end
  end

  assign gen_char = vcd_pkg::ASCII_ZERO[5:0] + {2'b00, vcd_pkg::tab_inv(prod)};

  // outputs
  always_comb begin
    busy         = 1'b1;
    valid_o      = 1'b0;
    check_char_o = vcd_pkg::ASCII_ZERO[5:0];
    check_ok_o   = 1'b0;
    status_o     = err_q;
    case (state_q)
      vcd_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      vcd_pkg::ST_WALK: begin
        busy = 1'b1;
      end
      vcd_pkg::ST_DONE: begin
        valid_o = 1'b1;
        if (err_q == vcd_pkg::STAT_OK) begin
          if (mode_q) begin
            check_char_o = gen_char;
            check_ok_o   = 1'b1;
          end else begin
            check_ok_o   = (prod == 4'd0);
          end
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != vcd_pkg::STAT_OK) |->
    (!check_ok_o && check_char_o == vcd_pkg::ASCII_ZERO[5:0]))
    else $error("error result carries a check value");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(vcd_pkg::MaxDigits))
    else $error("digit count past storage");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vcd_pkg::ST_WALK) |-> (left_q <= cnt_q))
    else $error("walk index beyond stored digits");

  a_gen_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && mode_q && status_o == vcd_pkg::STAT_OK) |-> check_ok_o)
    else $error("generate result not flagged ok");

endmodule

/* tb/verhoeff_result_monitor.sv */
`timescale 1ns / 1ps

module verhoeff_result_monitor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mode_we_i,
  input  logic       mode_wdata_i,
  input  logic       start,
  input  logic       busy,
  input  logic [7:0] digit_char_i,
  input  logic       last_i,
  input  logic       valid_o,
  input  logic [5:0] check_char_o,
  input  logic       check_ok_o,
  input  logic [1:0] status_o,
  output int         pending_o,
  output int         mismatches_o
);

  typedef struct packed {
    logic [5:0] check_char;
    logic       check_ok;
    logic [1:0] status;
  } verdict_t;

  verdict_t                 pending_verdicts[$];
  logic [3:0]               stored_digits[vcd_pkg::MaxDigits];
  logic [vcd_pkg::CntW-1:0] stored_count;
  logic [1:0]               string_error;
  logic                     gen_mode;
  int                       mismatch_count;

  assign mismatches_o = mismatch_count;

  // table rows packed as ten nibbles, column 0 in the top nibble
  function automatic logic [39:0] d_row(input logic [3:0] r);
    case (r)
      4'd0:    d_row = 40'h0123456789;
      4'd1:    d_row = 40'h1234067895;
      4'd2:    d_row = 40'h2340178956;
      4'd3:    d_row = 40'h3401289567;
      4'd4:    d_row = 40'h4012395678;
      4'd5:    d_row = 40'h5987604321;
      4'd6:    d_row = 40'h6598710432;
      4'd7:    d_row = 40'h7659821043;
      4'd8:    d_row = 40'h8765932104;
      default: d_row = 40'h9876543210;
    endcase
  endfunction

  function automatic logic [39:0] p_row(input logic [2:0] r);
    case (r)
      3'd0:    p_row = 40'h0123456789;
      3'd1:    p_row = 40'h1576283094;
      3'd2:    p_row = 40'h5803796142;
      3'd3:    p_row = 40'h8916043527;
      3'd4:    p_row = 40'h9453126870;
      3'd5:    p_row = 40'h4286573901;
      3'd6:    p_row = 40'h2793806415;
      default: p_row = 40'h7046913258;
    endcase
  endfunction

  localparam logic [39:0] InvRow = 40'h0432156789;

  function automatic logic [3:0] nib(input logic [39:0] row, input logic [3:0] col);
    logic [39:0] sh;
    sh = row >> (4 * (9 - int'(col)));
    nib = sh[3:0];
  endfunction

  // right-to-left fold of the stored digits
  function automatic logic [3:0] fold_digits(input logic gen, input int n);
    logic [3:0] prod;
    logic [3:0] pv;
    logic [2:0] pos;
    prod = 4'd0;
    for (int k = 0; k < n; k++) begin
      pos  = k[2:0] + {2'b00, gen};
      pv   = nib(p_row(pos), stored_digits[n - 1 - k]);
      prod = nib(d_row(prod), pv);
    end
    fold_digits = prod;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic absorb_char(input logic [7:0] ch, input logic lst);
    verdict_t   v;
    logic [3:0] prod;
    if (ch < vcd_pkg::ASCII_ZERO || ch > vcd_pkg::ASCII_NINE) begin
      if (string_error == vcd_pkg::STAT_OK) string_error = vcd_pkg::STAT_NONDIGIT;
    end else if (int'(stored_count) >= vcd_pkg::MaxDigits) begin
      if (string_error == vcd_pkg::STAT_OK) string_error = vcd_pkg::STAT_OVERFLOW;
    end else begin
      stored_digits[stored_count[vcd_pkg::AddrW-1:0]] = 4'(ch - vcd_pkg::ASCII_ZERO);
      stored_count = stored_count + vcd_pkg::CntW'(1);
    end
    if (lst) begin
      v.check_char = vcd_pkg::ASCII_ZERO[5:0];
      v.check_ok   = 1'b0;
      v.status     = string_error;
      if (string_error == vcd_pkg::STAT_OK) begin
        prod = fold_digits(gen_mode, int'(stored_count));
        if (gen_mode) begin
          v.check_char = vcd_pkg::ASCII_ZERO[5:0] + {2'b00, nib(InvRow, prod)};
          v.check_ok   = 1'b1;
        end else begin
          v.check_ok = (prod == 4'd0);
        end
      end
      pending_verdicts.push_back(v);
      stored_count = '0;
      string_error = vcd_pkg::STAT_OK;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      pending_verdicts.delete();
      stored_count   = '0;
      string_error   = vcd_pkg::STAT_OK;
      gen_mode       = 1'b0;
      mismatch_count = 0;
      pending_o     <= 0;
    end else begin
      if (valid_o) begin
        if (pending_verdicts.size() == 0) begin
          report("unexpected result", int'(status_o), -1);
        end else begin
          want = pending_verdicts.pop_front();
          if (check_char_o !== want.check_char)
            report("check_char", int'(check_char_o), int'(want.check_char));
          if (check_ok_o !== want.check_ok)
            report("check_ok", int'(check_ok_o), int'(want.check_ok));
          if (status_o !== want.status)
            report("status", int'(status_o), int'(want.status));
        end
      end
      if (mode_we_i) gen_mode = mode_wdata_i;
      if (start && !busy) absorb_char(digit_char_i, last_i);
      pending_o <= pending_verdicts.size();
    end
  end

endmodule

/* tb/tb_verhoeff_check_digit.sv */
`timescale 1ns / 1ps

module tb_verhoeff_check_digit;

  logic       clk_i;
  logic       rst_ni;
  logic       mode_we_i;
  logic       mode_wdata_i;
  logic       start;
  logic       busy;
  logic [7:0] digit_char_i;
  logic       last_i;
  logic       valid_o;
  logic [5:0] check_char_o;
  logic       check_ok_o;
  logic [1:0] status_o;
  int         pending;
  int         mismatches;
  int         sent_items;
  bit         no_gaps;

  verhoeff_check_digit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_we_i   (mode_we_i),
    .mode_wdata_i(mode_wdata_i),
    .start       (start),
    .busy        (busy),
    .digit_char_i(digit_char_i),
    .last_i      (last_i),
    .valid_o     (valid_o),
    .check_char_o(check_char_o),
    .check_ok_o  (check_ok_o),
    .status_o    (status_o)
  );

  verhoeff_result_monitor monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_we_i   (mode_we_i),
    .mode_wdata_i(mode_wdata_i),
    .start       (start),
    .busy        (busy),
    .digit_char_i(digit_char_i),
    .last_i      (last_i),
    .valid_o     (valid_o),
    .check_char_o(check_char_o),
    .check_ok_o  (check_ok_o),
    .status_o    (status_o),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_char(input logic [7:0] ch, input logic lst);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    digit_char_i <= ch;
    last_i       <= lst;
    do @(posedge clk_i); while (busy);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // one edge first so the last request is seen as busy or pending
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic v);
    drain();
    repeat (4) @(posedge clk_i);
    mode_we_i    <= 1'b1;
    mode_wdata_i <= v;
    @(posedge clk_i);
    mode_we_i    <= 1'b0;
  endtask

  task automatic send_random_string;
    int         len;
    int         pick;
    bit         noisy;
    logic [7:0] ch;
    pick  = $urandom_range(0, 99);
    if (pick < 70)      len = $urandom_range(1, 12);
    else if (pick < 90) len = $urandom_range(13, vcd_pkg::MaxDigits);
    else                len = $urandom_range(vcd_pkg::MaxDigits - 1, vcd_pkg::MaxDigits + 4);
    noisy = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) ch = 8'($urandom_range(0, 255));
      else ch = vcd_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
      send_char(ch, i == len - 1);
    end
  endtask

  initial begin
    int strings_done;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    mode_we_i    <= 1'b0;
    mode_wdata_i <= 1'b0;
    digit_char_i <= 8'd0;
    last_i       <= 1'b0;
    sent_items   = 0;
    no_gaps      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // validate mode out of reset
    send_text("2363");
    send_text("2364");
    send_text("0");
    send_text("9");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("5/");
    send_text(":");
    set_mode(1'b1);
    send_text("236");
    send_text("12345");

    strings_done = 0;
    while (sent_items < 1950) begin
      if (strings_done % 25 == 24) set_mode(logic'($urandom_range(0, 1)));
      else if ($urandom_range(0, 29) == 0) drain();
      no_gaps = ($urandom_range(0, 3) == 0);
      send_random_string();
      strings_done++;
    end
    no_gaps = 1'b0;

    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* verhoeff_check_digit.f */
hdl/vcd_pkg.sv
hdl/vcd_mem.sv
hdl/vcd_alu.sv
hdl/verhoeff_check_digit.sv
tb/verhoeff_result_monitor.sv
tb/tb_verhoeff_check_digit.sv
